@@ hw/rtl/shc_pkg.sv @@
// ----------------------------------------------------------------------------
// shc_pkg - syntax highlight classifier package
// Class and quote codes, register indexes, row state and the per-character
// classification function.
// ----------------------------------------------------------------------------
package shc_pkg;

  typedef enum logic [1:0] {
    ClsNormal  = 2'd0,
    ClsComment = 2'd1,
    ClsString  = 2'd2,
    ClsNumber  = 2'd3
  } hl_class_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteDouble = 2'd1,
    QuoteSingle = 2'd2
  } quote_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgSyntaxActive  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStringsEnable = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNumbersEnable = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCommentLen    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCommentFirst  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCommentSecond = 3'd5;

  localparam logic [1:0] CommentLenMax = 2'd2;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] ChDigit9    = 8'h39;

  typedef struct packed {
    logic       syntax_active;
    logic       strings_enable;
    logic       numbers_enable;
    logic [1:0] comment_len;
    logic [7:0] comment_first;
    logic [7:0] comment_second;
  } cfg_t;

  typedef struct packed {
    quote_e    quote;
    logic      escape;
    logic      sep_before;
    hl_class_e prev_class;
    logic      in_comment;
  } row_state_t;

  localparam row_state_t RowStateReset = '{
    quote:      QuoteNone,
    escape:     1'b0,
    sep_before: 1'b1,
    prev_class: ClsNormal,
    in_comment: 1'b0
  };

  typedef struct packed {
    hl_class_e  cls;
    row_state_t st;
  } cls_res_t;

  typedef struct packed {
    logic [7:0] ch;
    hl_class_e  cls;
    logic       last;
  } out_word_t;

  function automatic logic is_sep(logic [7:0] c);
    logic r;
    case (c)
      8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20,
      8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A,
      8'h3D, 8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h3B: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // class one character and, with highlighting on, advance the row state
  function automatic cls_res_t classify(row_state_t st, cfg_t cfg, logic [7:0] c,
                                        logic has_next, logic [7:0] nx);
    cls_res_t r;
    logic     is_digit;
    logic     quote_close;
    r.st        = st;
    r.cls       = ClsNormal;
    is_digit    = (c >= ChDigit0) && (c <= ChDigit9);
    quote_close = ((st.quote == QuoteDouble) && (c == ChDquote)) ||
                  ((st.quote == QuoteSingle) && (c == ChSquote));
    if (cfg.syntax_active) begin
      if (st.in_comment) begin
        r.cls = ClsComment;
      end else if (st.escape) begin
        r.st.escape = 1'b0;
        r.cls       = ClsString;
      end else if ((cfg.comment_len != 2'd0) && (st.quote == QuoteNone) &&
                   (c == cfg.comment_first) &&
                   ((cfg.comment_len == 2'd1) || (has_next && (nx == cfg.comment_second))))
      begin
        r.st.in_comment = 1'b1;
        r.cls           = ClsComment;
      end else if (cfg.strings_enable && (st.quote != QuoteNone)) begin
        r.cls = ClsString;
        if ((c == ChBackslash) && has_next) begin
          r.st.escape = 1'b1;
        end else begin
          if (quote_close) r.st.quote = QuoteNone;
          r.st.sep_before = 1'b1;
        end
      end else if (cfg.strings_enable && ((c == ChDquote) || (c == ChSquote))) begin
        r.st.quote = (c == ChDquote) ? QuoteDouble : QuoteSingle;
        r.cls      = ClsString;
      end else if (cfg.numbers_enable &&
                   ((is_digit && (st.sep_before || (st.prev_class == ClsNumber))) ||
                    ((c == ChDot) && (st.prev_class == ClsNumber)))) begin
        r.cls           = ClsNumber;
        r.st.sep_before = 1'b0;
      end else begin
        r.cls           = ClsNormal;
        r.st.sep_before = is_sep(c);
      end
      r.st.prev_class = r.cls;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/syntax_highlight_classifier.sv @@
// ----------------------------------------------------------------------------
// syntax_highlight_classifier - per-character highlight classes for a row
// Holds one character of lookahead and classes it when the next arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one character word per
//   cycle while in_ready_o is high, with row_end_i on the last character
//   of a row. Output channel (out_valid_o / out_ready_i) gives each
//   character back with its class. A character is classed when the
//   following one is accepted, so results lag by one character; the
//   row-end word flushes the held character, if any, and itself. Results
//   pass through a three-word queue. Throughput: one character per cycle
//   inside a row while the receiver keeps up; a row end that flushes a
//   held character puts two words into the queue, which the single output
//   port drains one at a time. A stalled receiver fills the queue;
//   in_ready_o drops while more than one word waits. Reset empties the
//   queue, clears the row state and loads the register defaults.
//   Configuration writes (cfg_we_i) take effect on the next edge; the user
//   must make them only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module syntax_highlight_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [shc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  ch_i,
  input  logic                        row_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_char_o,
  output logic [1:0]                  hl_class_o,
  output logic                        last_of_row_o
);
  import shc_pkg::*;

  localparam int unsigned QDepth = 3;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  cfg_t       cfg_q, cfg_d;
  row_state_t st_q, st_d;
  logic [7:0] held_char_q, held_char_d;
  logic       held_valid_q, held_valid_d;

  out_word_t           fifo_q [QDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     count_q, count_d;

  logic      in_acc, pop, push_a, push_b;
  cls_res_t  res_a, res_b;
  row_state_t st_mid;
  out_word_t word_a, word_b;
  logic [1:0] cfg_len_w;

  // configuration
  assign cfg_len_w = (cfg_data_i[1:0] > CommentLenMax) ? CommentLenMax : cfg_data_i[1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSyntaxActive:  cfg_d.syntax_active  = cfg_data_i[0];
        CfgStringsEnable: cfg_d.strings_enable = cfg_data_i[0];
        CfgNumbersEnable: cfg_d.numbers_enable = cfg_data_i[0];
        CfgCommentLen:    cfg_d.comment_len    = cfg_len_w;
        CfgCommentFirst:  cfg_d.comment_first  = cfg_data_i;
        CfgCommentSecond: cfg_d.comment_second = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // classification of held char (with lookahead) then row-end char
  assign in_acc = in_valid_i && in_ready_o;
  assign push_a = in_acc && held_valid_q;
  assign push_b = in_acc && row_end_i;

  always_comb begin
    res_a  = classify(st_q, cfg_q, held_char_q, 1'b1, ch_i);
    st_mid = held_valid_q ? res_a.st : st_q;
    res_b  = classify(st_mid, cfg_q, ch_i, 1'b0, 8'h00);
    word_a = '{ch: held_char_q, cls: res_a.cls, last: 1'b0};
    word_b = '{ch: ch_i, cls: res_b.cls, last: 1'b1};
  end

  always_comb begin
    st_d         = st_q;
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    if (in_acc) begin
      if (row_end_i) begin
        st_d         = RowStateReset;
        held_char_d  = '0;
        held_valid_d = 1'b0;
      end else begin
        st_d         = st_mid;
        held_char_d  = ch_i;
        held_valid_d = 1'b1;
      end
    end
  end

  // result queue
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (count_q <= CntW'(QDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_char_o    = fifo_q[rd_q].ch;
  assign hl_class_o    = fifo_q[rd_q].cls;
  assign last_of_row_o = fifo_q[rd_q].last;

  always_comb begin
    wr_d = wr_q;
    if (push_a) wr_d = ptr_inc(wr_d);
    if (push_b) wr_d = ptr_inc(wr_d);
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = CntW'(count_q + CntW'(push_a) + CntW'(push_b) - CntW'(pop));
  end

  always_ff @(posedge clk_i) begin
    if (push_a) fifo_q[wr_q] <= word_a;
    if (push_b) fifo_q[push_a ? ptr_inc(wr_q) : wr_q] <= word_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '{syntax_active: 1'b0, strings_enable: 1'b1, numbers_enable: 1'b1,
                        comment_len: 2'd2, comment_first: 8'd47, comment_second: 8'd47};
      st_q         <= RowStateReset;
      held_char_q  <= '0;
      held_valid_q <= 1'b0;
      wr_q         <= '0;
      rd_q         <= '0;
      count_q      <= '0;
    end else begin
      cfg_q        <= cfg_d;
      st_q         <= st_d;
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
      wr_q         <= wr_d;
      rd_q         <= rd_d;
      count_q      <= count_d;
    end
  end

  // a row end always leaves a clean row behind
  a_row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && row_end_i) |=> (!held_valid_q && (st_q == RowStateReset)))
    else $error("row state not cleared after row end");

  // with highlighting off the row state does not move
  a_inactive_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !row_end_i && !cfg_q.syntax_active && !cfg_we_i) |=> $stable(st_q))
    else $error("row state advanced while highlighting is off");

  // queue never overflows
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CntW'(QDepth)))
    else $error("result queue overflow");

endmodule

@@ tb/sv/tb_syntax_highlight_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_syntax_highlight_classifier - self-checking bench for the row classifier
// Streams text rows through the valid/ready input with random gaps and
// receiver stalls. A bench-side highlighter classes every character under the
// current register set, and each returned word is compared in order.
// ----------------------------------------------------------------------------
module tb_syntax_highlight_classifier;
  import shc_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseChars   = 165;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldAfter    = 100;
  localparam int unsigned HoldCycles   = 120;

  typedef struct packed {
    logic [7:0] ch;
    logic       row_end;
  } text_word_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [7:0]           cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           ch_i        = '0;
  logic                 row_end_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           out_char_o;
  logic [1:0]           hl_class_o;
  logic                 last_of_row_o;

  syntax_highlight_classifier uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .row_end_i    (row_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .hl_class_o   (hl_class_o),
    .last_of_row_o(last_of_row_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  text_word_t  text_q[$];
  out_word_t   classed_q[$];
  int unsigned tx_gap_max = 0;
  int unsigned rx_gap_max = 0;
  int unsigned tx_wait    = 0;
  int unsigned rx_wait    = 0;
  int unsigned chars_sent = 0;
  int unsigned rows_sent  = 0;
  int unsigned words_seen = 0;
  int unsigned settings   = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;

  // bench copy of the registers and of the row state
  cfg_t        hl_cfg;
  quote_e      open_quote;
  logic        escape_next;
  logic        after_sep;
  logic        comment_on;
  hl_class_e   last_cls;
  logic        hold_vld;
  logic [7:0]  hold_ch;

  function automatic logic breaks_word(logic [7:0] c);
    case (c)
      8'h00, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h2C, 8'h2E, 8'h28, 8'h29,
      8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h3D, 8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D,
      8'h3B:   return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_row_state();
    open_quote  = QuoteNone;
    escape_next = 1'b0;
    after_sep   = 1'b1;
    comment_on  = 1'b0;
    last_cls    = ClsNormal;
    hold_vld    = 1'b0;
    hold_ch     = 8'h00;
  endfunction

  // class c with one character of lookahead; a length of three acts as two
  function automatic hl_class_e class_char(logic [7:0] c, logic has_next, logic [7:0] nx);
    hl_class_e k;
    logic      digit;
    logic      prefix_hit;
    digit      = (c >= ChDigit0) && (c <= ChDigit9);
    prefix_hit = (hl_cfg.comment_len != 2'd0) && (open_quote == QuoteNone) &&
                 (c == hl_cfg.comment_first) &&
                 ((hl_cfg.comment_len == 2'd1) || (has_next && (nx == hl_cfg.comment_second)));
    if (!hl_cfg.syntax_active) return ClsNormal;
    if (comment_on) begin
      k = ClsComment;
    end else if (escape_next) begin
      escape_next = 1'b0;
      k = ClsString;
    end else if (prefix_hit) begin
      comment_on = 1'b1;
      k = ClsComment;
    end else if (hl_cfg.strings_enable && (open_quote != QuoteNone)) begin
      k = ClsString;
      if ((c == ChBackslash) && has_next) begin
        escape_next = 1'b1;
      end else begin
        if (((open_quote == QuoteDouble) && (c == ChDquote)) ||
            ((open_quote == QuoteSingle) && (c == ChSquote))) open_quote = QuoteNone;
        after_sep = 1'b1;
      end
    end else if (hl_cfg.strings_enable && ((c == ChDquote) || (c == ChSquote))) begin
      open_quote = (c == ChDquote) ? QuoteDouble : QuoteSingle;
      k = ClsString;
    end else if (hl_cfg.numbers_enable &&
                 ((digit && (after_sep || (last_cls == ClsNumber))) ||
                  ((c == ChDot) && (last_cls == ClsNumber)))) begin
      k = ClsNumber;
      after_sep = 1'b0;
    end else begin
      k = ClsNormal;
      after_sep = breaks_word(c);
    end
    last_cls = k;
    return k;
  endfunction

  function automatic void expect_words(logic [7:0] c, logic row_end);
    out_word_t w;
    if (hold_vld) begin
      w.ch   = hold_ch;
      w.cls  = class_char(hold_ch, 1'b1, c);
      w.last = 1'b0;
      classed_q.push_back(w);
    end
    if (row_end) begin
      w.ch   = c;
      w.cls  = class_char(c, 1'b0, 8'h00);
      w.last = 1'b1;
      classed_q.push_back(w);
      clear_row_state();
    end else begin
      hold_ch  = c;
      hold_vld = 1'b1;
    end
  endfunction

  // sender: one word per handshake, random gap after each
  always @(posedge clk_i) begin : drive_text
    text_word_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expect_words(ch_i, row_end_i);
        chars_sent++;
        tx_wait = $urandom_range(0, tx_gap_max);
      end
      if (!in_valid_i || in_ready_o) begin
        if ((tx_wait == 0) && (text_q.size() != 0)) begin
          nxt = text_q.pop_front();
          in_valid_i <= 1'b1;
          ch_i       <= nxt.ch;
          row_end_i  <= nxt.row_end;
        end else begin
          in_valid_i <= 1'b0;
          if (tx_wait != 0) tx_wait--;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin : check_words
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        if (classed_q.size() == 0) begin
          $error("unexpected word: out_char %0d hl_class %0d last_of_row %0d",
                 out_char_o, hl_class_o, last_of_row_o);
          errors++;
        end else begin
          want = classed_q.pop_front();
          if (out_char_o !== want.ch) begin
            $error("out_char: expected %0d, got %0d", want.ch, out_char_o);
            errors++;
          end
          if (hl_class_o !== want.cls) begin
            $error("hl_class: expected %0d, got %0d", want.cls, hl_class_o);
            errors++;
          end
          if (last_of_row_o !== want.last) begin
            $error("last_of_row: expected %0d, got %0d", want.last, last_of_row_o);
            errors++;
          end
        end
        rx_wait = $urandom_range(0, rx_gap_max);
        // one long hold so the output queue fills and input backs up
        if (words_seen == HoldAfter) rx_wait = HoldCycles;
      end
      if (rx_wait != 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgSyntaxActive:  hl_cfg.syntax_active  = val[0];
      CfgStringsEnable: hl_cfg.strings_enable = val[0];
      CfgNumbersEnable: hl_cfg.numbers_enable = val[0];
      CfgCommentLen:    hl_cfg.comment_len    = val[1:0];
      CfgCommentFirst:  hl_cfg.comment_first  = val;
      CfgCommentSecond: hl_cfg.comment_second = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_cfg(cfg_t c);
    write_reg(CfgSyntaxActive, {7'd0, c.syntax_active});
    write_reg(CfgStringsEnable, {7'd0, c.strings_enable});
    write_reg(CfgNumbersEnable, {7'd0, c.numbers_enable});
    write_reg(CfgCommentLen, {6'd0, c.comment_len});
    write_reg(CfgCommentFirst, c.comment_first);
    write_reg(CfgCommentSecond, c.comment_second);
    settings++;
  endtask

  task automatic wait_idle();
    while ((text_q.size() != 0) || in_valid_i || (classed_q.size() != 0)) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void push_char(logic [7:0] c, logic row_end);
    text_word_t w;
    w.ch      = c;
    w.row_end = row_end;
    text_q.push_back(w);
    if (row_end) rows_sent++;
  endfunction

  function automatic void push_text(string s, logic closes_row);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], closes_row && (i == s.len() - 1));
  endfunction

  // biased toward the characters that steer the classes
  function automatic logic [7:0] pick_char();
    string seps;
    int    r;
    seps = ",.()+-/*=~%<>[]; \t";
    r    = $urandom_range(0, 19);
    case (r)
      0, 1, 2, 3: return ChDigit0 + 8'($urandom_range(0, 9));
      4:          return ChDot;
      5:          return ChDquote;
      6:          return ChSquote;
      7:          return ChBackslash;
      8, 9:       return hl_cfg.comment_first;
      10:         return hl_cfg.comment_second;
      11, 12:     return seps[$urandom_range(0, seps.len() - 1)];
      13, 14, 15: return 8'h61 + 8'($urandom_range(0, 25));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned push_random_row();
    int unsigned len;
    logic        noise;
    len   = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
    noise = ($urandom_range(0, 9) == 0);
    for (int unsigned i = 0; i < len; i++)
      push_char(noise ? 8'($urandom_range(0, 255)) : pick_char(), i == len - 1);
    return len;
  endfunction

  initial begin : run
    cfg_t        ph;
    int unsigned n;
    hl_cfg = '{syntax_active: 1'b0, strings_enable: 1'b1, numbers_enable: 1'b1,
               comment_len: 2'd2, comment_first: 8'h2F, comment_second: 8'h2F};
    clear_row_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: highlighting off, every class normal
    @(negedge clk_i);
    push_text("9/", 1'b1);
    wait_idle();

    // highlighting on, other registers still at their reset values
    write_reg(CfgSyntaxActive, 8'd1);
    tx_gap_max = 3;
    rx_gap_max = 3;
    @(negedge clk_i);
    push_text("7.2a /", 1'b1);     // number runs, prefix start on the last char
    push_text("\"\\\"\"//", 1'b1); // escaped quote, close, then comment
    push_text("'a\\", 1'b1);       // backslash as the last char of the row
    push_char(8'h80, 1'b0);
    push_char(8'h00, 1'b0);
    push_text("1", 1'b1);
    wait_idle();

    write_reg(CfgCommentLen, 8'd1);
    write_reg(CfgCommentFirst, 8'h23);
    @(negedge clk_i);
    push_text("a#b", 1'b1);
    wait_idle();

    // strings switched off while a string is still open
    write_reg(CfgCommentLen, 8'd2);
    write_reg(CfgCommentFirst, 8'h2F);
    @(negedge clk_i);
    push_text("\"a", 1'b0);
    wait_idle();
    write_reg(CfgStringsEnable, 8'd0);
    @(negedge clk_i);
    push_text("//1\"", 1'b1);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: ph = '{1'b1, 1'b1, 1'b1, 2'd2, 8'h2F, 8'h2F};
        1: ph = '{1'b1, 1'b0, 1'b1, 2'd1, 8'h00, 8'hFF};
        2: ph = '{1'b1, 1'b1, 1'b0, 2'd3, 8'hFF, 8'h00};
        3: ph = '{1'b0, 1'b1, 1'b1, 2'd2, 8'h2D, 8'h2D};
        4: ph = '{1'b1, 1'b1, 1'b1, 2'd0, 8'h23, 8'h23};
        default: begin
          ph.syntax_active  = ($urandom_range(0, 7) != 0);
          ph.strings_enable = 1'($urandom_range(0, 1));
          ph.numbers_enable = 1'($urandom_range(0, 1));
          ph.comment_len    = 2'($urandom_range(0, 3));
          ph.comment_first  = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h2F;
          ph.comment_second = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h2A;
        end
      endcase
      write_cfg(ph);
      tx_gap_max = (p % 3 == 0) ? 0 : 18;
      rx_gap_max = (p % 4 == 1) ? 0 : 18;
      @(negedge clk_i);
      n = 0;
      while (n < PhaseChars) n += push_random_row();
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    $display("sent %0d characters in %0d rows under %0d register settings", chars_sent,
             rows_sent, settings + 1);
    $display("checked %0d classified words", words_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ syntax_highlight_classifier.f @@
hw/rtl/shc_pkg.sv
hw/rtl/syntax_highlight_classifier.sv
tb/sv/tb_syntax_highlight_classifier.sv
